>>> rtl/core/rsld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB status LED pattern driver package
// Shared field widths, command and pattern codes, register map, item types
// and the sine table generator used to build the brightness ROM.
// ----------------------------------------------------------------------------
package rsld_pkg;

	// Field widths of the item and result channels.
	localparam int CMD_W     = 2;
	localparam int TIME_W    = 32;
	localparam int STATUS_W  = 3;
	localparam int DUTY_W    = 8;
	localparam int PATTERN_W = 3;

	// Configuration register widths and reset values.
	localparam int INTERVAL_W = 10;
	localparam int STEP_W     = 16;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 10'd33;
	localparam logic [STEP_W-1:0]     STEP_RESET     = 16'd834;

	// APB register map: one 32-bit register every four bytes.
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_LSB = 2;
	localparam logic REG_FRAME_INTERVAL = 1'b0;
	localparam logic REG_PHASE_STEP     = 1'b1;

	// Item kinds.
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LINK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;

	// Highest room status code that maps to a pattern (the error status).
	localparam logic [STATUS_W-1:0] STATUS_MAX_MAPPED = 3'd4;

	// Pattern codes.
	localparam logic [PATTERN_W-1:0] PAT_OFF        = 3'd0;
	localparam logic [PATTERN_W-1:0] PAT_GREEN      = 3'd1;
	localparam logic [PATTERN_W-1:0] PAT_PULSE_BLUE = 3'd2;
	localparam logic [PATTERN_W-1:0] PAT_FLASH_RED  = 3'd3;
	localparam logic [PATTERN_W-1:0] PAT_RED        = 3'd4;
	localparam logic [PATTERN_W-1:0] PAT_WHITE      = 3'd5;
	localparam logic [PATTERN_W-1:0] PAT_DISCONN    = 3'd6;

	// Brightness levels.
	localparam logic [DUTY_W-1:0] LEVEL_FULL    = 8'd255;
	localparam logic [DUTY_W-1:0] LEVEL_DIM_RED = 8'd30;
	localparam logic [DUTY_W-1:0] LEVEL_DARK    = 8'd0;

	// Sine generator constants, Q28 fixed point.
	localparam longint unsigned Q28_ONE     = 64'd268435456;
	localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

	// Configuration register contents.
	typedef struct packed {
		logic [INTERVAL_W-1:0] frame_interval_ms;
		logic [STEP_W-1:0]     phase_step;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [TIME_W-1:0]   now_ms;
		logic                connected_flag;
		logic [STATUS_W-1:0] status_code;
	} item_t;

	// One result item.
	typedef struct packed {
		logic                 frame_written;
		logic [DUTY_W-1:0]    red_duty;
		logic [DUTY_W-1:0]    green_duty;
		logic [DUTY_W-1:0]    blue_duty;
		logic [PATTERN_W-1:0] active_pattern;
	} result_t;

	// Sine of a Q28 angle in the first quadrant: degree-11 Taylor series in
	// Horner form with truncating steps, clamped to one.
	function automatic longint unsigned sine_q28(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		begin
			x2 = (x * x) >> 28;
			t  = Q28_ONE;
			t  = Q28_ONE - ((x2 * t) >> 28) / 110;
			t  = Q28_ONE - ((x2 * t) >> 28) / 72;
			t  = Q28_ONE - ((x2 * t) >> 28) / 42;
			t  = Q28_ONE - ((x2 * t) >> 28) / 20;
			t  = Q28_ONE - ((x2 * t) >> 28) / 6;
			t  = (x * t) >> 28;
			sine_q28 = (t > Q28_ONE) ? Q28_ONE : t;
		end
	endfunction

	// Table entry: brightness 0..255 of a raised sine over one period.
	function automatic logic [DUTY_W-1:0] sine_entry(input int unsigned addr,
		input int unsigned addr_bits);
		int unsigned     qbits;
		int unsigned     quarter;
		int unsigned     quad;
		int unsigned     r;
		longint unsigned s;
		longint unsigned level;
		begin
			qbits   = addr_bits - 2;
			quarter = 1 << qbits;
			quad    = (addr >> qbits) & 3;
			r       = addr & (quarter - 1);
			if (quad[0]) begin
				r = quarter - r;
			end
			s = sine_q28((longint'(r) * HALF_PI_Q28) >> qbits);
			if (quad[1]) begin
				level = (64'd255 * (Q28_ONE - s)) >> 29;
			end else begin
				level = (64'd255 * (Q28_ONE + s)) >> 29;
			end
			sine_entry = level[DUTY_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/rsld_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel that carries one timestamped input item.
// ----------------------------------------------------------------------------
interface rsld_in_if;
	logic                          valid;
	logic                          ready;
	logic [rsld_pkg::CMD_W-1:0]    cmd;
	logic [rsld_pkg::TIME_W-1:0]   now_ms;
	logic                          connected_flag;
	logic [rsld_pkg::STATUS_W-1:0] status_code;

	modport source(output valid, cmd, now_ms, connected_flag, status_code, input ready);
	modport sink(input valid, cmd, now_ms, connected_flag, status_code, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rsld_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one LED frame result.
// ----------------------------------------------------------------------------
interface rsld_out_if;
	logic                           valid;
	logic                           ready;
	logic                           frame_written;
	logic [rsld_pkg::DUTY_W-1:0]    red_duty;
	logic [rsld_pkg::DUTY_W-1:0]    green_duty;
	logic [rsld_pkg::DUTY_W-1:0]    blue_duty;
	logic [rsld_pkg::PATTERN_W-1:0] active_pattern;

	modport source(output valid, frame_written, red_duty, green_duty, blue_duty,
		active_pattern, input ready);
	modport sink(input valid, frame_written, red_duty, green_duty, blue_duty,
		active_pattern, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rgb_status_led_pattern_driver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB status LED pattern driver
// Turns timestamped ticks, link events and status updates into
// common-anode PWM duties for a status LED.
//
//   Port        Dir   Carries
//   in_ch       in    cmd, now_ms, connected_flag, status_code
//   out_ch      out   frame_written, red/green/blue duty, active_pattern
//   APB (p*)    in    frame_interval_ms (0x0), phase_step (0x4)
//
// One item enters per cycle when no stage is stalled; its result reaches out_ch
// through three stages that compute the flash table address, the last of
// which feeds the pattern state update and the result register.
// Stages move up whenever the stage ahead is empty, so a stalled output stops
// only the full stages.
// Reset brings the LED dark and the pattern off at once; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_status_led_pattern_driver_top #(
	parameter int PHASE_BITS      = 16,
	parameter int SINE_ADDR_BITS  = 8,
	parameter int FLASH_PERIOD_MS = 1500
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	rsld_in_if.sink                                in_ch,
	rsld_out_if.source                             out_ch,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rsld_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [rsld_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [rsld_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	rsld_pkg::cfg_t            cfg;
	logic                      s3_valid;
	logic                      s3_ready;
	rsld_pkg::item_t           s3_item;
	logic [SINE_ADDR_BITS-1:0] s3_flash_addr;

	// Configuration registers.
	rsld_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Flash address pipeline.
	rsld_flash_idx #(
		.SINE_ADDR_BITS (SINE_ADDR_BITS),
		.FLASH_PERIOD_MS(FLASH_PERIOD_MS)
	) u_flash (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.s3_valid     (s3_valid),
		.s3_item      (s3_item),
		.s3_flash_addr(s3_flash_addr),
		.s3_ready     (s3_ready)
	);

	// Pattern state and frame rendering.
	rsld_core #(
		.PHASE_BITS    (PHASE_BITS),
		.SINE_ADDR_BITS(SINE_ADDR_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.s3_valid     (s3_valid),
		.s3_item      (s3_item),
		.s3_flash_addr(s3_flash_addr),
		.s3_ready     (s3_ready),
		.out_ch       (out_ch)
	);

endmodule

`default_nettype wire

>>> rtl/core/rsld_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the frame interval and the phase step.
// ----------------------------------------------------------------------------
module rsld_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [rsld_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [rsld_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [rsld_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output rsld_pkg::cfg_t                         cfg
);

	rsld_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic           reg_idx;

	// Register select and write strobe of the access phase.
	assign reg_idx = paddr[rsld_pkg::REG_IDX_LSB];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_interval_ms <= rsld_pkg::INTERVAL_RESET;
			cfg_q.phase_step        <= rsld_pkg::STEP_RESET;
		end else if (wr_en) begin
			if (reg_idx == rsld_pkg::REG_FRAME_INTERVAL) begin
				cfg_q.frame_interval_ms <= pwdata[rsld_pkg::INTERVAL_W-1:0];
			end else begin
				cfg_q.phase_step <= pwdata[rsld_pkg::STEP_W-1:0];
			end
		end
	end

	// Read mux.
	always_comb begin
		if (reg_idx == rsld_pkg::REG_PHASE_STEP) begin
			prdata = rsld_pkg::APB_DATA_W'(cfg_q.phase_step);
		end else begin
			prdata = rsld_pkg::APB_DATA_W'(cfg_q.frame_interval_ms);
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/rsld_flash_idx.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Flash phase index pipeline
// Three stages that carry each item forward and compute its flash table
// address ((now_ms mod FLASH_PERIOD_MS) * 2^SINE_ADDR_BITS) / FLASH_PERIOD_MS
// with reciprocal multiplies instead of dividers.
// ----------------------------------------------------------------------------
module rsld_flash_idx #(
	parameter int SINE_ADDR_BITS  = 8,
	parameter int FLASH_PERIOD_MS = 1500
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	rsld_in_if.sink                        in_ch,
	output logic                           s3_valid,
	output rsld_pkg::item_t                s3_item,
	output logic [SINE_ADDR_BITS-1:0]      s3_flash_addr,
	input  wire logic                      s3_ready
);

	// Period width: FLASH_PERIOD_MS <= 2^CL.
	localparam int CL   = $clog2(FLASH_PERIOD_MS);
	localparam int RW   = CL + 1;
	// Floor reciprocal for the modulo, 2^32 / period.
	localparam int M1_W = 33 - CL;
	localparam logic [M1_W-1:0] M1 = M1_W'((64'd1 << 32) / FLASH_PERIOD_MS);
	localparam int P1_W = 32 + M1_W;
	localparam int P2_W = M1_W + CL;
	localparam logic [RW-1:0] PERIOD = RW'(FLASH_PERIOD_MS);
	// Ceiling reciprocal for the scaling, exact for every remainder.
	localparam int S2   = 2 * CL + SINE_ADDR_BITS;
	localparam int K_W  = CL + SINE_ADDR_BITS + 2;
	localparam logic [K_W-1:0] K =
		K_W'(((64'd1 << S2) + FLASH_PERIOD_MS - 1) / FLASH_PERIOD_MS);
	localparam int P3_W = CL + K_W;

	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic                  rdy_s1;
	logic                  rdy_s2;
	logic                  rdy_s3;
	rsld_pkg::item_t       item_s1;
	rsld_pkg::item_t       item_s2;
	rsld_pkg::item_t       item_s3;
	logic [M1_W-1:0]       quo_s1;
	logic [RW-1:0]         rem_s2;
	logic [SINE_ADDR_BITS-1:0] addr_s3;
	logic [P1_W-1:0]       prod1;
	logic [P2_W-1:0]       prod2;
	logic [RW-1:0]         rem_fix;
	logic [CL-1:0]         rem_mod;
	logic [P3_W-1:0]       prod3;

	// Each stage takes a new item when empty or when its item moves on.
	assign rdy_s3      = !v_s3 || s3_ready;
	assign rdy_s2      = !v_s2 || rdy_s3;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;

	// Stage 1: quotient estimate, at most one below the true quotient.
	assign prod1 = P1_W'(in_ch.now_ms) * P1_W'(M1);

	// Stage 2: remainder estimate, below twice the period.
	assign prod2 = P2_W'(quo_s1) * P2_W'(PERIOD);

	// Stage 3: correct the remainder and scale it to a table address.
	assign rem_fix = (rem_s2 >= PERIOD) ? (rem_s2 - PERIOD) : rem_s2;
	assign rem_mod = rem_fix[CL-1:0];
	assign prod3   = P3_W'(rem_mod) * P3_W'(K);

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_ch.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid) begin
			item_s1.cmd            <= in_ch.cmd;
			item_s1.now_ms         <= in_ch.now_ms;
			item_s1.connected_flag <= in_ch.connected_flag;
			item_s1.status_code    <= in_ch.status_code;
			quo_s1                 <= prod1[P1_W-1:32];
		end
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_s1;
			rem_s2  <= item_s1.now_ms[RW-1:0] - prod2[RW-1:0];
		end
		if (rdy_s3 && v_s2) begin
			item_s3 <= item_s2;
			addr_s3 <= prod3[2*CL +: SINE_ADDR_BITS];
		end
	end

	assign s3_valid      = v_s3;
	assign s3_item       = item_s3;
	assign s3_flash_addr = addr_s3;

endmodule

`default_nettype wire

>>> rtl/core/rsld_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sine brightness ROM
// Constant table of one raised sine period with two read ports, one for the
// pulse phase and one for the flash phase.
// ----------------------------------------------------------------------------
module rsld_sine_rom #(
	parameter int ADDR_BITS = 8
) (
	input  wire logic [ADDR_BITS-1:0]          pulse_addr,
	input  wire logic [ADDR_BITS-1:0]          flash_addr,
	output logic      [rsld_pkg::DUTY_W-1:0]   pulse_level,
	output logic      [rsld_pkg::DUTY_W-1:0]   flash_level
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [rsld_pkg::DUTY_W-1:0] rom_tbl [DEPTH];

	// Table contents are fixed at elaboration.
	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		localparam logic [rsld_pkg::DUTY_W-1:0] LEVEL = rsld_pkg::sine_entry(i, ADDR_BITS);
		assign rom_tbl[i] = LEVEL;
	end

	assign pulse_level = rom_tbl[pulse_addr];
	assign flash_level = rom_tbl[flash_addr];

endmodule

`default_nettype wire

>>> rtl/core/rsld_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern state and frame renderer
// Holds link, pattern, phase and frame time state. Unless out_ch stalls, it
// applies one item per cycle, renders a frame on a due tick, registers results.
// ----------------------------------------------------------------------------
module rsld_core #(
	parameter int PHASE_BITS     = 16,
	parameter int SINE_ADDR_BITS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rsld_pkg::cfg_t            cfg,
	input  wire logic                      s3_valid,
	input  wire rsld_pkg::item_t           s3_item,
	input  wire logic [SINE_ADDR_BITS-1:0] s3_flash_addr,
	output logic                           s3_ready,
	rsld_out_if.source                     out_ch
);

	logic [rsld_pkg::PATTERN_W-1:0] pattern_q;
	logic                           breathe_q;
	logic                           link_up_q;
	logic [PHASE_BITS-1:0]          phase_q;
	logic [rsld_pkg::TIME_W-1:0]    last_frame_q;
	logic [rsld_pkg::DUTY_W-1:0]    red_q;
	logic [rsld_pkg::DUTY_W-1:0]    green_q;
	logic [rsld_pkg::DUTY_W-1:0]    blue_q;
	logic                           out_valid_q;
	rsld_pkg::result_t              res_q;

	logic [rsld_pkg::PATTERN_W-1:0] pattern_d;
	logic                           breathe_d;
	logic                           link_up_d;
	logic [PHASE_BITS-1:0]          phase_d;
	logic [rsld_pkg::TIME_W-1:0]    last_frame_d;
	logic [rsld_pkg::DUTY_W-1:0]    red_d;
	logic [rsld_pkg::DUTY_W-1:0]    green_d;
	logic [rsld_pkg::DUTY_W-1:0]    blue_d;
	logic                           written_d;
	logic                           sel_req;
	logic [rsld_pkg::PATTERN_W-1:0] sel_pattern;
	logic [rsld_pkg::TIME_W-1:0]    elapsed;
	logic                           tick_due;
	logic [PHASE_BITS-1:0]          phase_adv;
	logic [SINE_ADDR_BITS-1:0]      pulse_addr;
	logic [rsld_pkg::DUTY_W-1:0]    pulse;
	logic [rsld_pkg::DUTY_W-1:0]    flash;
	logic [rsld_pkg::DUTY_W-1:0]    bri_r;
	logic [rsld_pkg::DUTY_W-1:0]    bri_g;
	logic [rsld_pkg::DUTY_W-1:0]    bri_b;
	logic                           take;

	// The result register frees up when empty or when its result is taken.
	assign s3_ready = !out_valid_q || out_ch.ready;
	assign take     = s3_valid && s3_ready;

	// Tick timing and the phase of a frame rendered now.
	assign elapsed   = s3_item.now_ms - last_frame_q;
	assign tick_due  = elapsed >= rsld_pkg::TIME_W'(cfg.frame_interval_ms);
	assign phase_adv = phase_q + PHASE_BITS'(cfg.phase_step);

	// Top bits of the phase address the sine table.
	if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_hi
		assign pulse_addr = phase_adv[PHASE_BITS-1 -: SINE_ADDR_BITS];
	end else begin : g_addr_lo
		assign pulse_addr = {phase_adv, (SINE_ADDR_BITS - PHASE_BITS)'(0)};
	end

	rsld_sine_rom #(
		.ADDR_BITS(SINE_ADDR_BITS)
	) u_rom (
		.pulse_addr (pulse_addr),
		.flash_addr (s3_flash_addr),
		.pulse_level(pulse),
		.flash_level(flash)
	);

	// Per-pattern brightness of a rendered frame.
	always_comb begin
		bri_r = rsld_pkg::LEVEL_DARK;
		bri_g = rsld_pkg::LEVEL_DARK;
		bri_b = rsld_pkg::LEVEL_DARK;
		case (pattern_q)
			rsld_pkg::PAT_GREEN: begin
				bri_g = breathe_q ? pulse : rsld_pkg::LEVEL_FULL;
			end
			rsld_pkg::PAT_PULSE_BLUE: begin
				bri_b = pulse;
			end
			rsld_pkg::PAT_FLASH_RED: begin
				bri_r = breathe_q ? pulse : flash;
			end
			rsld_pkg::PAT_RED: begin
				bri_r = breathe_q ? pulse : rsld_pkg::LEVEL_FULL;
			end
			rsld_pkg::PAT_WHITE: begin
				bri_r = pulse;
				bri_g = pulse;
				bri_b = pulse;
			end
			rsld_pkg::PAT_DISCONN: begin
				bri_r = rsld_pkg::LEVEL_DIM_RED;
				bri_g = pulse;
				bri_b = pulse;
			end
			default: begin
			end
		endcase
	end

	// Item decode: frame ticks, link events and room status updates.
	always_comb begin
		pattern_d    = pattern_q;
		breathe_d    = breathe_q;
		link_up_d    = link_up_q;
		phase_d      = phase_q;
		last_frame_d = last_frame_q;
		red_d        = red_q;
		green_d      = green_q;
		blue_d       = blue_q;
		written_d    = 1'b0;
		sel_req      = 1'b0;
		sel_pattern  = pattern_q;
		case (s3_item.cmd)
			rsld_pkg::CMD_TICK: begin
				if (tick_due) begin
					last_frame_d = s3_item.now_ms;
					phase_d      = phase_adv;
					red_d        = rsld_pkg::LEVEL_FULL - bri_r;
					green_d      = rsld_pkg::LEVEL_FULL - bri_g;
					blue_d       = rsld_pkg::LEVEL_FULL - bri_b;
					written_d    = 1'b1;
				end
			end
			rsld_pkg::CMD_LINK: begin
				link_up_d = s3_item.connected_flag;
				if (!s3_item.connected_flag) begin
					sel_req     = 1'b1;
					sel_pattern = rsld_pkg::PAT_DISCONN;
				end
			end
			rsld_pkg::CMD_STATUS: begin
				if (link_up_q && (s3_item.status_code <= rsld_pkg::STATUS_MAX_MAPPED)) begin
					sel_req     = 1'b1;
					sel_pattern = s3_item.status_code + 3'd1;
				end
			end
			default: begin
			end
		endcase
		// A new pattern restarts the phase and the frame timer.
		if (sel_req && (sel_pattern != pattern_q)) begin
			pattern_d    = sel_pattern;
			phase_d      = '0;
			last_frame_d = s3_item.now_ms;
			breathe_d    = 1'b0;
		end
	end

	// Pattern state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= rsld_pkg::PAT_OFF;
			breathe_q    <= 1'b1;
			link_up_q    <= 1'b0;
			phase_q      <= '0;
			last_frame_q <= '0;
			red_q        <= rsld_pkg::LEVEL_FULL;
			green_q      <= rsld_pkg::LEVEL_FULL;
			blue_q       <= rsld_pkg::LEVEL_FULL;
		end else if (take) begin
			pattern_q    <= pattern_d;
			breathe_q    <= breathe_d;
			link_up_q    <= link_up_d;
			phase_q      <= phase_d;
			last_frame_q <= last_frame_d;
			red_q        <= red_d;
			green_q      <= green_d;
			blue_q       <= blue_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s3_ready) begin
			out_valid_q <= s3_valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (take) begin
			res_q.frame_written  <= written_d;
			res_q.red_duty       <= red_d;
			res_q.green_duty     <= green_d;
			res_q.blue_duty      <= blue_d;
			res_q.active_pattern <= pattern_d;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.frame_written  = res_q.frame_written;
	assign out_ch.red_duty       = res_q.red_duty;
	assign out_ch.green_duty     = res_q.green_duty;
	assign out_ch.blue_duty      = res_q.blue_duty;
	assign out_ch.active_pattern = res_q.active_pattern;

endmodule

`default_nettype wire
